@@ hw/rtl/yiqlo_pkg.sv @@
// shared constants and weight function for the yiq luma offset pipeline
`default_nettype none

package yiqlo_pkg;

	localparam int PIX_W   = 8;
	localparam int TDATA_W = 3 * PIX_W;
	localparam int OFS_W   = 9;

	// weights in thousandths
	localparam int M_YR = 299;
	localparam int M_YG = 587;
	localparam int M_YB = 114;
	localparam int M_IR = 596;
	localparam int M_IG = -275;
	localparam int M_IB = -321;
	localparam int M_QR = 212;
	localparam int M_QG = -523;
	localparam int M_QB = 311;
	localparam int M_RI = 956;
	localparam int M_RQ = 621;
	localparam int M_GI = -272;
	localparam int M_GQ = -647;
	localparam int M_BI = -1108;
	localparam int M_BQ = 1705;

	// round(milli/1000 * 2^frac), halves away from zero
	function automatic int coef(input int milli, input int frac);
		int mag;
		int q;
		mag = (milli < 0) ? -milli : milli;
		q = (mag * (1 << frac) + 500) / 1000;
		return (milli < 0) ? -q : q;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/yiq_luma_offset_pixel.sv @@
// top level: rgb pixel brightness adjust through yiq, four register stages
// an accepted word passes through stages s1 to s4 before its result word reaches the master side
// throughput: one pixel per cycle while the output is not held, as all four stages share one enable
// a stalled output freezes every stage, so nothing is lost or repeated
// reset clears all stage valid bits and sets the luma offset to zero
`default_nettype none

module yiq_luma_offset_pixel #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [yiqlo_pkg::TDATA_W-1:0]      s_tdata,  // in_red, in_green, in_blue
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [yiqlo_pkg::TDATA_W-1:0]           m_tdata,  // out_red, out_green, out_blue
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [yiqlo_pkg::OFS_W-1:0]        cfg_data  // luma_offset
);

	localparam int PW = yiqlo_pkg::PIX_W;

	logic                                  en;
	logic signed [yiqlo_pkg::OFS_W-1:0]    luma_offset_q;
	logic                                  valid_s2;
	logic signed [10:0]                    y_s2;
	logic signed [9:0]                     i_s2;
	logic signed [9:0]                     q_s2;
	logic [PW-1:0]                         red_s4, green_s4, blue_s4;

	// whole pipeline advances unless the output word is held
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			luma_offset_q <= cfg_data;
		end
	end

	yiqlo_fwd #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_fwd (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.in_red     (s_tdata[PW-1:0]),
		.in_green   (s_tdata[2*PW-1:PW]),
		.in_blue    (s_tdata[3*PW-1:2*PW]),
		.luma_offset(luma_offset_q),
		.valid_s2   (valid_s2),
		.y_s2       (y_s2),
		.i_s2       (i_s2),
		.q_s2       (q_s2)
	);

	yiqlo_inv #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_inv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_s2(valid_s2),
		.y_s2    (y_s2),
		.i_s2    (i_s2),
		.q_s2    (q_s2),
		.valid_s4(m_tvalid),
		.red_s4  (red_s4),
		.green_s4(green_s4),
		.blue_s4 (blue_s4)
	);

	assign m_tdata = {blue_s4, green_s4, red_s4};

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> luma_offset_q == $past(cfg_data))
		else $error("luma offset not taken from config write");

	a_mid_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s2 ##1 en |=> m_tvalid)
		else $error("word lost between middle and output stage");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s2) && m_tvalid)
		else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

@@ hw/rtl/yiqlo_fwd.sv @@
// rgb to yiq stages: weight products, then sums, truncation and luma offset
`default_nettype none

module yiqlo_fwd #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                in_valid,
	input  wire logic [yiqlo_pkg::PIX_W-1:0]         in_red,
	input  wire logic [yiqlo_pkg::PIX_W-1:0]         in_green,
	input  wire logic [yiqlo_pkg::PIX_W-1:0]         in_blue,
	input  wire logic signed [yiqlo_pkg::OFS_W-1:0]  luma_offset,
	output logic                                     valid_s2,
	output logic signed [10:0]                       y_s2,
	output logic signed [9:0]                        i_s2,
	output logic signed [9:0]                        q_s2
);

	localparam int CW = COEF_FRAC_BITS + 3;
	localparam int W  = COEF_FRAC_BITS + 12;

	localparam logic signed [CW-1:0] C_YR = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_YR, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_YG = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_YG, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_YB = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_YB, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_IR = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_IR, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_IG = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_IG, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_IB = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_IB, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_QR = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_QR, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_QG = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_QG, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_QB = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_QB, COEF_FRAC_BITS));

	localparam logic signed [W-1:0] RND = (W'(1) << COEF_FRAC_BITS) - W'(1);

	// divide by 2^frac, truncating toward zero
	function automatic logic signed [W-1:0] trunc_div(input logic signed [W-1:0] s);
		logic signed [W-1:0] b;
		b = s + (s[W-1] ? RND : W'(0));
		return b >>> COEF_FRAC_BITS;
	endfunction

	logic signed [W-1:0] r_ext, g_ext, b_ext;
	logic                valid_s1;
	logic signed [W-1:0] pyr_s1, pyg_s1, pyb_s1;
	logic signed [W-1:0] pir_s1, pig_s1, pib_s1;
	logic signed [W-1:0] pqr_s1, pqg_s1, pqb_s1;
	logic signed [W-1:0] y_sum, i_sum, q_sum;
	logic signed [W-1:0] y_d, i_d, q_d;

	assign r_ext = W'(signed'({1'b0, in_red}));
	assign g_ext = W'(signed'({1'b0, in_green}));
	assign b_ext = W'(signed'({1'b0, in_blue}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pyr_s1 <= r_ext * W'(C_YR);
			pyg_s1 <= g_ext * W'(C_YG);
			pyb_s1 <= b_ext * W'(C_YB);
			pir_s1 <= r_ext * W'(C_IR);
			pig_s1 <= g_ext * W'(C_IG);
			pib_s1 <= b_ext * W'(C_IB);
			pqr_s1 <= r_ext * W'(C_QR);
			pqg_s1 <= g_ext * W'(C_QG);
			pqb_s1 <= b_ext * W'(C_QB);
		end
	end

	assign y_sum = pyr_s1 + pyg_s1 + pyb_s1;
	assign i_sum = pir_s1 + pig_s1 + pib_s1;
	assign q_sum = pqr_s1 + pqg_s1 + pqb_s1;
	assign y_d   = trunc_div(y_sum);
	assign i_d   = trunc_div(i_sum);
	assign q_d   = trunc_div(q_sum);

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= {y_d[9], y_d[9:0]} + {{2{luma_offset[8]}}, luma_offset};
			i_s2 <= i_d[9:0];
			q_s2 <= q_d[9:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/yiqlo_inv.sv @@
// yiq to rgb stages: weight products, then sums, truncation and clamp
`default_nettype none

module yiqlo_inv #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          valid_s2,
	input  wire logic signed [10:0]            y_s2,
	input  wire logic signed [9:0]             i_s2,
	input  wire logic signed [9:0]             q_s2,
	output logic                               valid_s4,
	output logic [yiqlo_pkg::PIX_W-1:0]        red_s4,
	output logic [yiqlo_pkg::PIX_W-1:0]        green_s4,
	output logic [yiqlo_pkg::PIX_W-1:0]        blue_s4
);

	localparam int CW = COEF_FRAC_BITS + 3;
	localparam int W  = COEF_FRAC_BITS + 12;

	localparam logic signed [CW-1:0] C_RI = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_RI, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_RQ = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_RQ, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_GI = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_GI, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_GQ = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_GQ, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_BI = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_BI, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_BQ = CW'(yiqlo_pkg::coef(yiqlo_pkg::M_BQ, COEF_FRAC_BITS));

	localparam logic signed [W-1:0] RND = (W'(1) << COEF_FRAC_BITS) - W'(1);
	localparam logic signed [W-1:0] MAXV = W'(255);

	function automatic logic signed [W-1:0] trunc_div(input logic signed [W-1:0] s);
		logic signed [W-1:0] b;
		b = s + (s[W-1] ? RND : W'(0));
		return b >>> COEF_FRAC_BITS;
	endfunction

	function automatic logic [yiqlo_pkg::PIX_W-1:0] clamp8(input logic signed [W-1:0] v);
		logic [yiqlo_pkg::PIX_W-1:0] res;
		if (v[W-1])
			res = '0;
		else if (v > MAXV)
			res = '1;
		else
			res = v[yiqlo_pkg::PIX_W-1:0];
		return res;
	endfunction

	logic signed [W-1:0] i_ext, q_ext;
	logic                valid_s3;
	logic signed [W-1:0] py_s3;
	logic signed [W-1:0] pri_s3, prq_s3, pgi_s3, pgq_s3, pbi_s3, pbq_s3;
	logic signed [W-1:0] r_d, g_d, b_d;

	assign i_ext = W'(i_s2);
	assign q_ext = W'(q_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// luma weight is exactly one
			py_s3  <= W'(y_s2) <<< COEF_FRAC_BITS;
			pri_s3 <= i_ext * W'(C_RI);
			prq_s3 <= q_ext * W'(C_RQ);
			pgi_s3 <= i_ext * W'(C_GI);
			pgq_s3 <= q_ext * W'(C_GQ);
			pbi_s3 <= i_ext * W'(C_BI);
			pbq_s3 <= q_ext * W'(C_BQ);
		end
	end

	assign r_d = trunc_div(py_s3 + pri_s3 + prq_s3);
	assign g_d = trunc_div(py_s3 + pgi_s3 + pgq_s3);
	assign b_d = trunc_div(py_s3 + pbi_s3 + pbq_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			red_s4   <= clamp8(r_d);
			green_s4 <= clamp8(g_d);
			blue_s4  <= clamp8(b_d);
		end
	end

endmodule

`default_nettype wire
